FILE: rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    // Field widths of one item
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 7;
    localparam int CNT_W    = 3;
    localparam int ACC_W    = PEND_W + CODE_W;
    localparam int ENTRY_W  = LEN_W + CODE_W;

    // Longest code the data path can carry
    localparam int CODE_MAX_LEN = 16;

    // Parameter defaults
    localparam int SYMBOL_COUNT_DEF    = 256;
    localparam int MAX_CODE_LENGTH_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // Item held in the execute register
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } exec_item_t;

    // Packing result for one item
    typedef struct packed {
        logic [1:0]        n;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              last;
        logic              upd;
        logic [PEND_W-1:0] pend_bits;
        logic [CNT_W-1:0]  pend_cnt;
    } pack_res_t;

endpackage

FILE: rtl/core/huffman_code_bit_packer_core.sv
// Huffman code bit packer.
// Input stream (s_*): one item per handshake. s_tuser holds the operation: 0 loads a
// table entry (symbol, right-aligned code_bits, code_length from s_tdata), 1 encodes
// a symbol, 2 flushes the partial byte. Output stream (m_*): packed bytes, first code
// bit in bit 7; m_tlast marks the zero-padded byte produced by a flush.
// Timing: an item is registered on accept while its table entry is read from
// the code RAM; once the two-entry output queue has room for its bytes, it is
// packed into the queue, whose head register drives m_tdata. Each item yields
// zero, one or two bytes; the one-byte output port sets the pace: one item per
// cycle when items give at most one byte and m_tready stays high; an item that
// gives two bytes can hold the next item back. A load followed at once by an
// encode of the same symbol sees the new entry. Reset clears the entry valid
// bits (every symbol reads as length zero), the pending bits and the output
// queue; no clearing pass is needed, the block is ready as soon as reset is
// released. When m_tready is low, bytes wait in the queue and s_tready drops
// once the queue cannot take the next item's bytes; nothing is lost or reordered.
module huffman_code_bit_packer_core #(
    parameter int SYMBOL_COUNT    = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] symbol, [23:8] code_bits, [28:24] code_length, [31:29] zero
    input  logic [31:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // last_byte
    output logic        m_tlast
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int LEN_CAP = (MAX_CODE_LENGTH < hcbp_pkg::CODE_MAX_LEN) ?
                             MAX_CODE_LENGTH : hcbp_pkg::CODE_MAX_LEN;

    // Input fields
    logic [hcbp_pkg::OP_W-1:0]   s_op;
    logic [hcbp_pkg::SYM_W-1:0]  s_sym;
    logic [hcbp_pkg::CODE_W-1:0] s_code;
    logic [hcbp_pkg::LEN_W-1:0]  s_len;

    assign s_op   = s_tuser;
    assign s_sym  = s_tdata[7:0];
    assign s_code = s_tdata[23:8];
    assign s_len  = s_tdata[28:24];

    logic                          accept_in;
    logic                          in_range;
    logic [ADDR_W-1:0]             sym_idx;
    logic [hcbp_pkg::LEN_W-1:0]    ld_len;
    logic [hcbp_pkg::CODE_W-1:0]   ld_code;
    logic                          tbl_wr;
    logic [hcbp_pkg::ENTRY_W-1:0]  rd_entry;

    assign accept_in = s_tvalid && s_tready;
    assign in_range  = {1'b0, s_sym} < 9'(SYMBOL_COUNT);
    assign sym_idx   = s_sym[ADDR_W-1:0];

    // Load: saturate length, clear code bits above it
    assign ld_len  = (s_len > hcbp_pkg::LEN_W'(LEN_CAP)) ?
                     hcbp_pkg::LEN_W'(LEN_CAP) : s_len;
    assign ld_code = s_code & hcbp_pkg::CODE_W'((17'd1 << ld_len) - 17'd1);
    assign tbl_wr  = accept_in && (s_op == hcbp_pkg::OP_LOAD) && in_range;

    // Code table
    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_ram (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (sym_idx),
        .wr_data ({ld_len, ld_code}),
        .rd_en   (accept_in),
        .rd_addr (sym_idx),
        .rd_data (rd_entry)
    );

    // Entry valid bits; an unwritten entry reads as length zero
    logic [SYMBOL_COUNT-1:0] tbl_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_valid_reg <= '0;
        end else if (tbl_wr) begin
            tbl_valid_reg[sym_idx] <= 1'b1;
        end
    end

    // Execute register
    logic                        e_valid_reg;
    logic [hcbp_pkg::OP_W-1:0]   e_op_reg;
    logic                        e_hit_reg;
    logic                        e_retire;
    hcbp_pkg::exec_item_t        e_item;
    hcbp_pkg::pack_res_t         res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (s_tready) begin
            e_valid_reg <= s_tvalid;
        end
        if (accept_in) begin
            e_op_reg  <= s_op;
            e_hit_reg <= in_range && tbl_valid_reg[sym_idx];
        end
    end

    assign e_item.op   = e_op_reg;
    assign e_item.hit  = e_hit_reg;
    assign e_item.code = rd_entry[hcbp_pkg::CODE_W-1:0];
    assign e_item.len  = rd_entry[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W];

    // Pending bit accumulator
    logic [hcbp_pkg::PEND_W-1:0] pend_bits_reg;
    logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_reg;

    hcbp_pack u_pack (
        .item      (e_item),
        .pend_bits (pend_bits_reg),
        .pend_cnt  (pend_cnt_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (e_retire && res.upd) begin
            pend_bits_reg <= res.pend_bits;
            pend_cnt_reg  <= res.pend_cnt;
        end
    end

    // Two-entry output queue: head drives the port, tail waits behind it
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       t_valid_reg;
    logic [7:0] t_data_reg;
    logic       t_last_reg;

    logic       pop;
    logic [1:0] occ;
    logic [1:0] free_slots;
    logic [1:0] np;
    logic       q0_v, q0_l, q1_v, q1_l;
    logic [7:0] q0_d, q1_d;
    logic       h_v_next, h_l_next, t_v_next, t_l_next;
    logic [7:0] h_d_next, t_d_next;

    assign pop        = m_tvalid_reg && m_tready;
    assign occ        = {1'b0, m_tvalid_reg} + {1'b0, t_valid_reg};
    assign free_slots = 2'd2 - occ + {1'b0, pop};
    assign e_retire   = e_valid_reg && (free_slots >= res.n);
    assign s_tready   = !e_valid_reg || e_retire;
    assign np         = e_retire ? res.n : 2'd0;

    always_comb begin
        // Entries left after this cycle's pop
        if (pop) begin
            q0_v = t_valid_reg;
            q0_d = t_data_reg;
            q0_l = t_last_reg;
            q1_v = 1'b0;
        end else begin
            q0_v = m_tvalid_reg;
            q0_d = m_tdata_reg;
            q0_l = m_tlast_reg;
            q1_v = t_valid_reg;
        end
        q1_d = t_data_reg;
        q1_l = t_last_reg;

        // Head slot
        h_v_next = 1'b0;
        h_d_next = q0_d;
        h_l_next = q0_l;
        if (q0_v) begin
            h_v_next = 1'b1;
        end else if (np != 2'd0) begin
            h_v_next = 1'b1;
            h_d_next = res.byte0;
            h_l_next = res.last;
        end

        // Tail slot
        t_v_next = 1'b0;
        t_d_next = q1_d;
        t_l_next = q1_l;
        if (q1_v) begin
            t_v_next = 1'b1;
        end else if (q0_v && np != 2'd0) begin
            t_v_next = 1'b1;
            t_d_next = res.byte0;
            t_l_next = res.last;
        end else if (!q0_v && np == 2'd2) begin
            t_v_next = 1'b1;
            t_d_next = res.byte1;
            t_l_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
        end else begin
            m_tvalid_reg <= h_v_next;
            t_valid_reg  <= t_v_next;
        end
        m_tdata_reg <= h_d_next;
        m_tlast_reg <= h_l_next;
        t_data_reg  <= t_d_next;
        t_last_reg  <= t_l_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // Tail entry never stands without a head entry
    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        t_valid_reg |-> m_tvalid_reg)
        else $error("output queue tail valid with empty head");

    // Pending bits above the count stay zero
    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_cnt_reg == '0) |-> (pend_bits_reg == '0))
        else $error("pending bits set with zero count");

    // A retired flush leaves the accumulator empty
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_retire && e_op_reg == hcbp_pkg::OP_FLUSH) |=> (pend_cnt_reg == '0))
        else $error("flush did not clear pending bits");

    // A padded last byte is only produced while bits are pending
    a_last_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_retire && res.last) |-> (pend_cnt_reg != '0))
        else $error("last byte emitted with nothing pending");
`endif

endmodule

FILE: rtl/core/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/hcbp_pack.sv
module hcbp_pack (
    input  hcbp_pkg::exec_item_t            item,
    input  logic [hcbp_pkg::PEND_W-1:0]     pend_bits,
    input  logic [hcbp_pkg::CNT_W-1:0]      pend_cnt,
    output hcbp_pkg::pack_res_t             res
);

    logic [hcbp_pkg::ACC_W-1:0]  acc;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [hcbp_pkg::LEN_W-1:0]  sh0;
    logic [hcbp_pkg::LEN_W-1:0]  sh1;
    logic [hcbp_pkg::PEND_W-1:0] keep_mask;
    logic [hcbp_pkg::BYTE_W-1:0] flush_byte;

    // Append code to pending bits, right-aligned
    assign acc   = (hcbp_pkg::ACC_W'(pend_bits) << item.len)
                 | hcbp_pkg::ACC_W'(item.code);
    assign total = hcbp_pkg::LEN_W'(pend_cnt) + item.len;
    assign sh0   = total - 5'd8;
    assign sh1   = total - 5'd16;
    assign keep_mask = hcbp_pkg::PEND_W'((8'd1 << total[2:0]) - 8'd1);

    // Partial byte padded with zeros on the right
    assign flush_byte = hcbp_pkg::BYTE_W'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt}));

    always_comb begin
        res           = '0;
        res.pend_bits = pend_bits;
        res.pend_cnt  = pend_cnt;
        unique case (item.op)
            hcbp_pkg::OP_ENCODE: begin
                if (item.hit && item.len != '0) begin
                    res.n         = total[4:3];
                    res.byte0     = acc[sh0 +: hcbp_pkg::BYTE_W];
                    res.byte1     = acc[sh1 +: hcbp_pkg::BYTE_W];
                    res.upd       = 1'b1;
                    res.pend_cnt  = total[2:0];
                    res.pend_bits = acc[hcbp_pkg::PEND_W-1:0] & keep_mask;
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                if (pend_cnt != '0) begin
                    res.n         = 2'd1;
                    res.byte0     = flush_byte;
                    res.last      = 1'b1;
                    res.upd       = 1'b1;
                    res.pend_cnt  = '0;
                    res.pend_bits = '0;
                end
            end
            default: begin
                res.n = 2'd0;
            end
        endcase
    end

endmodule
